// ----- rtl/gradient_noise_3d_top_assert.svh -----
// assertion macros shared by the noise pipeline
`ifndef GRADIENT_NOISE_3D_TOP_ASSERT_SVH
`define GRADIENT_NOISE_3D_TOP_ASSERT_SVH

// a held beat keeps its payload until taken
`define GN_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, dat) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(dat))) else $error("stalled beat changed");

// a general implication checked after reset
`define GN_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (pre) |-> (post)) else $error("implication failed");

// a next-cycle implication checked after reset
`define GN_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (pre) |=> (post)) else $error("next-cycle implication failed");

`endif

// ----- rtl/gn3d_pkg.sv -----
`timescale 1ns / 1ps
package gn3d_pkg;

  localparam int CoordW = 24;
  localparam int NoiseW = 16;

  // reference permutation
  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
    8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
    8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
    8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
    8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
    8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
    8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
    8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
    8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // hash gradient selector code
  typedef logic [3:0] grad_t;

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    return PERM[idx];
  endfunction

endpackage

// ----- rtl/gradient_noise_3d_top.sv -----
`timescale 1ns / 1ps
// Improved 3D gradient noise: one point per clock in, one Q2.14 value per clock out.
// An item passes through the pipeline (three hash stages beside the three-stage
// fade curve, corner gradients, three blend levels, output rounding); the whole pipe
// advances whenever the output register is empty or being taken, so throughput is one
// beat per cycle and a stall holds every stage in place.
module gradient_noise_3d_top import gn3d_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // coord_x [23:0], coord_y [47:24], coord_z [71:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // noise_value [15:0]
);
  localparam int Depth = 8;
  localparam int FW    = FRAC_BITS + 4;   // fade width
  localparam int VW    = FRAC_BITS + 4;   // signed dot / blend width
  localparam int CellLo = FRAC_BITS;

  logic en;
  logic [Depth-1:0] vld_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && rst_n;

  // valid bits ride with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Depth-2:0], in_tvalid};
  end
  assign out_tvalid = vld_r[Depth-1];

  // split coordinates: cell and fraction
  logic [CoordW-1:0] cx, cy, cz;
  assign cx = in_tdata[23:0];
  assign cy = in_tdata[47:24];
  assign cz = in_tdata[71:48];

  logic [FRAC_BITS-1:0] fx, fy, fz;
  logic [7:0] clx, cly, clz;
  assign fx  = cx[FRAC_BITS-1:0];
  assign fy  = cy[FRAC_BITS-1:0];
  assign fz  = cz[FRAC_BITS-1:0];
  assign clx = 8'(signed'(cx) >>> CellLo);
  assign cly = 8'(signed'(cy) >>> CellLo);
  assign clz = 8'(signed'(cz) >>> CellLo);

  // fade units
  logic [FW-1:0] fdx, fdy, fdz;
  gn3d_fade #(.FracBits(FRAC_BITS)) u_fx (.clk, .en, .t(fx), .fade(fdx));
  gn3d_fade #(.FracBits(FRAC_BITS)) u_fy (.clk, .en, .t(fy), .fade(fdy));
  gn3d_fade #(.FracBits(FRAC_BITS)) u_fz (.clk, .en, .t(fz), .fade(fdz));

  // hash stage 1: A, B
  logic [7:0] ha_r, hb_r, cz1_r;
  logic [FRAC_BITS-1:0] x1_r, y1_r, z1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ha_r  <= perm_lookup(clx) + cly;
      hb_r  <= perm_lookup(clx + 8'd1) + cly;
      cz1_r <= clz;
      x1_r <= fx; y1_r <= fy; z1_r <= fz;
    end
  end

  // hash stage 2: AA AB BA BB
  logic [7:0] haa_r, hab_r, hba_r, hbb_r;
  logic [FRAC_BITS-1:0] x2_r, y2_r, z2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      haa_r <= perm_lookup(ha_r) + cz1_r;
      hab_r <= perm_lookup(ha_r + 8'd1) + cz1_r;
      hba_r <= perm_lookup(hb_r) + cz1_r;
      hbb_r <= perm_lookup(hb_r + 8'd1) + cz1_r;
      x2_r <= x1_r; y2_r <= y1_r; z2_r <= z1_r;
    end
  end

  // hash stage 3: eight gradient codes, corner order bit0=x bit1=y bit2=z
  grad_t g_r [8];
  logic [FRAC_BITS-1:0] x3_r, y3_r, z3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      g_r[0] <= PERM[haa_r][3:0];
      g_r[1] <= PERM[hba_r][3:0];
      g_r[2] <= PERM[hab_r][3:0];
      g_r[3] <= PERM[hbb_r][3:0];
      g_r[4] <= PERM[8'(haa_r + 8'd1)][3:0];
      g_r[5] <= PERM[8'(hba_r + 8'd1)][3:0];
      g_r[6] <= PERM[8'(hab_r + 8'd1)][3:0];
      g_r[7] <= PERM[8'(hbb_r + 8'd1)][3:0];
      x3_r <= x2_r; y3_r <= y2_r; z3_r <= z2_r;
    end
  end

  // stage 4: corner dot products
  logic signed [VW-1:0] dot_r [8];
  logic signed [VW-1:0] px [2], py [2], pz [2];
  localparam logic signed [VW-1:0] OneV = VW'(1) << FRAC_BITS;
  assign px[0] = VW'(x3_r); assign px[1] = VW'(x3_r) - OneV;
  assign py[0] = VW'(y3_r); assign py[1] = VW'(y3_r) - OneV;
  assign pz[0] = VW'(z3_r); assign pz[1] = VW'(z3_r) - OneV;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        logic signed [VW-1:0] u, v, xx, yy, zz;
        grad_t h;
        h  = g_r[c];
        xx = px[c[0]];
        yy = py[c[1]];
        zz = pz[c[2]];
        u  = (h < 4'd8) ? xx : yy;
        v  = (h < 4'd4) ? yy : ((h == 4'd12 || h == 4'd14) ? xx : zz);
        dot_r[c] <= (h[0] ? -u : u) + (h[1] ? -v : v);
      end
    end
  end

  // fade values delayed to meet the blend levels (fade ready at stage 3)
  logic [FW-1:0] fdx5_r, fdy5_r, fdy6_r, fdz5_r, fdz6_r, fdz7_r;
  always_ff @(posedge clk) begin
    if (en) begin
      fdx5_r <= fdx;
      fdy5_r <= fdy; fdy6_r <= fdy5_r;
      fdz5_r <= fdz; fdz6_r <= fdz5_r; fdz7_r <= fdz6_r;
    end
  end

  // blend level x (stage 5)
  logic signed [VW-1:0] lx [4];
  for (genvar i = 0; i < 4; i++) begin : g_lx
    gn3d_lerp #(.FracBits(FRAC_BITS), .ValW(VW)) u_l (
      .clk, .en, .w(fdx5_r), .a(dot_r[2*i]), .b(dot_r[2*i+1]), .y(lx[i]));
  end
  // blend level y
  logic signed [VW-1:0] ly [2];
  for (genvar i = 0; i < 2; i++) begin : g_ly
    gn3d_lerp #(.FracBits(FRAC_BITS), .ValW(VW)) u_l (
      .clk, .en, .w(fdy6_r), .a(lx[2*i]), .b(lx[2*i+1]), .y(ly[i]));
  end
  // blend level z
  logic signed [VW-1:0] lz;
  gn3d_lerp #(.FracBits(FRAC_BITS), .ValW(VW)) u_lz (
    .clk, .en, .w(fdz7_r), .a(ly[0]), .b(ly[1]), .y(lz));

  // output rescale and saturate
  localparam int OW = VW + 24;
  localparam int ShUp = (OUT_FRAC_BITS >= FRAC_BITS) ? OUT_FRAC_BITS - FRAC_BITS : 0;
  localparam int ShDn = (OUT_FRAC_BITS < FRAC_BITS) ? FRAC_BITS - OUT_FRAC_BITS : 1;
  logic signed [OW-1:0] res;
  logic [NoiseW-1:0] out_r;
  always_comb begin
    if (OUT_FRAC_BITS >= FRAC_BITS)
      res = OW'(lz) <<< ShUp;
    else
      res = (OW'(lz) + (OW'(1) <<< (ShDn - 1))) >>> ShDn;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (res > OW'(32767))       out_r <= 16'h7fff;
      else if (res < -OW'(32768)) out_r <= 16'h8000;
      else                        out_r <= res[NoiseW-1:0];
    end
  end
  assign out_tdata = out_r;

  `include "gradient_noise_3d_top_assert.svh"
  `GN_ASSERT_HOLD(a_out_hold, clk, rst_n, out_tvalid, out_tready, out_tdata)
  `GN_ASSERT_IMP(a_ready_on_empty, clk, rst_n, !out_tvalid, in_tready)
  `GN_ASSERT_NXT(a_stall_freeze, clk, rst_n, out_tvalid && !out_tready,
    $stable(vld_r))
endmodule

// ----- rtl/gn3d_fade.sv -----
`timescale 1ns / 1ps
// quintic fade curve, three register stages, advances on en
module gn3d_fade import gn3d_pkg::*; #(
  parameter int FracBits = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [FracBits-1:0] t,
  output logic [FracBits+3:0] fade
);
  localparam int W = FracBits + 4;
  localparam logic [W-1:0] One = W'(1) << FracBits;

  logic [FracBits-1:0] t1_r;
  logic [W-1:0]        k_r, t2sq_r, s_r, t3_r2, fade_r;
  logic [2*W-1:0]      p_k, p_t2, p_t3, p_f;

  // stage 1: k = t*(15-6t), t^2
  assign p_k  = (2*W)'(t) * (2*W)'(W'(15) * One - W'(6) * W'(t));
  assign p_t2 = (2*W)'(t) * (2*W)'(t);
  // stage 2: s = 10-k, t^3
  assign p_t3 = (2*W)'(t2sq_r) * (2*W)'(t1_r);
  // stage 3: t^3 * s
  assign p_f  = (2*W)'(t3_r2) * (2*W)'(s_r);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= t;
      k_r    <= W'(p_k >> FracBits);
      t2sq_r <= W'(p_t2 >> FracBits);
      s_r    <= W'(10) * One - k_r;
      t3_r2  <= W'(p_t3 >> FracBits);
      fade_r <= W'(p_f >> FracBits);
    end
  end

  assign fade = fade_r;
endmodule

// ----- rtl/gn3d_lerp.sv -----
`timescale 1ns / 1ps
// one registered linear blend a + floor(w*(b-a)/2^F)
module gn3d_lerp import gn3d_pkg::*; #(
  parameter int FracBits = 16,
  parameter int ValW     = 20
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [FracBits+3:0]    w,
  input  logic signed [ValW-1:0] a,
  input  logic signed [ValW-1:0] b,
  output logic signed [ValW-1:0] y
);
  localparam int PW = ValW + FracBits + 6;
  logic signed [PW-1:0] prod;
  logic signed [ValW:0] diff;

  // difference one bit wider, then weight it
  assign diff = (ValW+1)'(b) - (ValW+1)'(a);
  always_comb begin
    prod = PW'(signed'({1'b0, w})) * PW'(diff);
  end

  always_ff @(posedge clk) begin
    if (en) y <= ValW'(a + ValW'(prod >>> FracBits));
  end
endmodule
